### rtl/ettpt_pkg.sv
// ---------------------------------------------------------------------------
// ettpt_pkg
// Shared types and operation codes for the epoch-tagged visited table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ettpt_pkg;

  localparam logic [2:0] OP_NEW_SEARCH = 3'd0;
  localparam logic [2:0] OP_ADD        = 3'd1;
  localparam logic [2:0] OP_MARK_GIVEN = 3'd2;
  localparam logic [2:0] OP_MARK_CUR   = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;
  localparam logic [2:0] OP_TRACE      = 3'd5;

  localparam logic [7:0] EPOCH_LAST = 8'd255;

  typedef struct packed {
    logic [2:0]         op;
    logic [15:0]        index;
    logic [15:0]        parent_index;
    logic signed [31:0] move_cost;
    logic [7:0]         tag_value;
    logic [11:0]        end_index;
    logic [6:0]         route_limit;
    logic               run_last;
  } req_t;

  typedef struct packed {
    logic [11:0]        route_point;
    logic               last;
    logic               overflow;
    logic               bad_index;
    logic               is_current;
    logic [11:0]        parent_out;
    logic signed [31:0] cost_out;
    logic [15:0]        marked_count;
    logic [7:0]         epoch_out;
    logic [5:0]         final_position;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/ettpt_ram.sv
// ---------------------------------------------------------------------------
// ettpt_ram
// Generic RAM with one write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ettpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/epoch_tag_table_with_parent_trace.sv
// ---------------------------------------------------------------------------
// epoch_tag_table_with_parent_trace
// Visited-set table with per-entry tag, parent and cost, a search epoch,
// mark counting and a parent-chain route trace.
// ---------------------------------------------------------------------------
// A beat is taken only while idle, and the RAM read is launched at the
// accepting edge; the result is registered from the execute state once the
// output is free. No new beat is taken until the last one is through. A
// trace passes a RAM-read state and an emit state for each route point,
// the parent RAM read of each hop being the limiting loop.
// A new search at epoch 255 clears the tag RAM first.
// After reset the tag RAM is cleared; no beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module epoch_tag_table_with_parent_trace
  import ettpt_pkg::*;
#(
  parameter int ENTRIES   = 4096,
  parameter int MAX_ROUTE = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = (AW > 12) ? AW : 12;
  localparam logic [16:0] ENTRIES_W = 17'(ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
  localparam logic [6:0] ROUTE_MAX = 7'(MAX_ROUTE);

  localparam logic [2:0] S_CLEAR      = 3'd0;
  localparam logic [2:0] S_IDLE       = 3'd1;
  localparam logic [2:0] S_EXEC       = 3'd2;
  localparam logic [2:0] S_TRACE_RD   = 3'd3;
  localparam logic [2:0] S_TRACE_EMIT = 3'd4;

  logic [2:0]    state, state_next;
  req_t          cur;
  logic [7:0]    epoch, epoch_next;
  logic [15:0]   mark_count, mark_count_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          new_pending, new_pending_next;
  logic [AW-1:0] itag, itag_next;
  logic [6:0]    pos, pos_next;
  logic [6:0]    limit, limit_next;

  logic          accept;
  logic          out_free;
  logic          emit;
  rsp_t          res;

  logic          tag_we;
  logic [AW-1:0] tag_waddr;
  logic [7:0]    tag_wdata;
  logic [7:0]    tag_rd;
  logic          pc_we;
  logic [43:0]   pc_rd;
  logic [AW-1:0] raddr;

  logic          idx_ok;
  logic          par_ok;
  logic          hop_ok;
  logic [7:0]    mark_tag;
  logic [15:0]   mark_sum;
  logic [6:0]    pos_inc;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign idx_ok   = {1'b0, cur.index} < ENTRIES_W;
  assign par_ok   = {1'b0, cur.parent_index} < ENTRIES_W;
  assign hop_ok   = {5'd0, pc_rd[43:32]} < ENTRIES_W;
  assign mark_tag = (cur.op == OP_MARK_GIVEN) ? cur.tag_value : epoch;
  assign mark_sum = mark_count + {15'd0, idx_ok};
  assign pos_inc  = pos + 7'd1;

  // The read address follows the incoming beat while idle so that the
  // entry is already out of the RAM in the cycle after acceptance.
  always_comb begin
    if (state == S_IDLE) begin
      raddr = req.index[AW-1:0];
    end else if (state == S_TRACE_RD || state == S_TRACE_EMIT) begin
      raddr = itag;
    end else begin
      raddr = cur.index[AW-1:0];
    end
  end

  always_comb begin
    state_next       = state;
    epoch_next       = epoch;
    mark_count_next  = mark_count;
    clr_addr_next    = clr_addr;
    new_pending_next = new_pending;
    itag_next        = itag;
    pos_next         = pos;
    limit_next       = limit;
    emit             = 1'b0;
    res              = '0;
    res.epoch_out    = epoch;
    tag_we           = 1'b0;
    tag_waddr        = cur.index[AW-1:0];
    tag_wdata        = epoch;
    pc_we            = 1'b0;

    case (state)
      S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_addr;
        tag_wdata = 8'd0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          new_pending_next = 1'b0;
          state_next = new_pending ? S_EXEC : S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cur.op == OP_NEW_SEARCH && epoch == EPOCH_LAST) begin
          // Tags wrap: sweep the tag RAM, then finish this item from epoch 0.
          epoch_next       = 8'd0;
          new_pending_next = 1'b1;
          clr_addr_next    = '0;
          state_next       = S_CLEAR;
        end else if (out_free) begin
          case (cur.op)
            OP_NEW_SEARCH: begin
              epoch_next    = epoch + 8'd1;
              res.epoch_out = epoch + 8'd1;
              res.last      = 1'b1;
              emit          = 1'b1;
              state_next    = S_IDLE;
            end
            OP_ADD: begin
              tag_we        = idx_ok && par_ok;
              pc_we         = idx_ok && par_ok;
              res.bad_index = !(idx_ok && par_ok);
              res.last      = 1'b1;
              emit          = 1'b1;
              state_next    = S_IDLE;
            end
            OP_MARK_GIVEN, OP_MARK_CUR: begin
              tag_we           = idx_ok;
              tag_wdata        = mark_tag;
              epoch_next       = mark_tag;
              res.epoch_out    = mark_tag;
              res.bad_index    = !idx_ok;
              res.marked_count = mark_sum;
              mark_count_next  = cur.run_last ? 16'd0 : mark_sum;
              res.last         = 1'b1;
              emit             = 1'b1;
              state_next       = S_IDLE;
            end
            OP_QUERY: begin
              if (idx_ok) begin
                res.is_current = (tag_rd == epoch);
                res.parent_out = pc_rd[43:32];
                res.cost_out   = pc_rd[31:0];
              end else begin
                res.bad_index = 1'b1;
              end
              res.last   = 1'b1;
              emit       = 1'b1;
              state_next = S_IDLE;
            end
            OP_TRACE: begin
              if (idx_ok) begin
                itag_next = cur.index[AW-1:0];
                pos_next  = 7'd0;
                if (cur.route_limit == 7'd0) begin
                  limit_next = 7'd1;
                end else if (cur.route_limit > ROUTE_MAX) begin
                  limit_next = ROUTE_MAX;
                end else begin
                  limit_next = cur.route_limit;
                end
                state_next = S_TRACE_RD;
              end else begin
                res.bad_index = 1'b1;
                res.last      = 1'b1;
                emit          = 1'b1;
                state_next    = S_IDLE;
              end
            end
            default: begin
              res.last   = 1'b1;
              emit       = 1'b1;
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_TRACE_RD: begin
        state_next = S_TRACE_EMIT;
      end

      S_TRACE_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (CW'(itag) == CW'(cur.end_index)) begin
            res.route_point    = cur.end_index;
            res.last           = 1'b1;
            res.final_position = pos[5:0];
            state_next         = S_IDLE;
          end else begin
            res.route_point = 12'(itag);
            pos_next        = pos_inc;
            if (pos_inc >= limit) begin
              res.overflow = 1'b1;
              res.last     = 1'b1;
              state_next   = S_IDLE;
            end else begin
              // A parent that points outside the table restarts at entry zero.
              itag_next  = hop_ok ? AW'(pc_rd[43:32]) : '0;
              state_next = S_TRACE_RD;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      epoch       <= 8'd0;
      mark_count  <= 16'd0;
      clr_addr    <= '0;
      new_pending <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      epoch       <= epoch_next;
      mark_count  <= mark_count_next;
      clr_addr    <= clr_addr_next;
      new_pending <= new_pending_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
    if (emit) begin
      rsp <= res;
    end
    itag  <= itag_next;
    pos   <= pos_next;
    limit <= limit_next;
  end

  ettpt_ram #(
    .WIDTH (8),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (raddr),
    .rdata (tag_rd)
  );

  ettpt_ram #(
    .WIDTH (44),
    .DEPTH (ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (pc_we),
    .waddr (cur.index[AW-1:0]),
    .wdata ({cur.parent_index[11:0], cur.move_cost}),
    .raddr (raddr),
    .rdata (pc_rd)
  );

  a_new_search_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && emit && cur.op == OP_NEW_SEARCH) |=> (rsp.epoch_out != 8'd0))
    else $error("new search produced epoch zero");

  a_trace_within_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRACE_EMIT) |-> (pos < limit && limit != 7'd0 && limit <= ROUTE_MAX))
    else $error("trace position beyond route limit");

  a_tag_write_source: assert property (@(posedge clk) disable iff (rst)
    tag_we |-> (state == S_CLEAR || state == S_EXEC))
    else $error("tag RAM written outside clear or execute");

endmodule

`default_nettype wire

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench for the epoch-tagged visited table. It drives table operations
// (directed corner cases first, then random search episodes of new search,
// add chains, mark runs, queries and traces) through a valid/stall channel.
// An in-bench copy of the table state predicts every result beat, and each
// beat is compared field by field under several idle and stall mixes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ettpt_pkg::*;

  localparam int TABLE_ENTRIES = 4096;
  localparam int ROUTE_MAX     = 64;
  localparam int LONG_HOLD     = 300;

  // Op codes 6 and 7 are unused by the block and must act as no-ops.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  epoch_tag_table_with_parent_trace #(
    .ENTRIES  (TABLE_ENTRIES),
    .MAX_ROUTE(ROUTE_MAX)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #1 clk = ~clk;

  // Shadow copy of the table.
  bit [7:0]  tag_mem     [TABLE_ENTRIES];
  bit [11:0] parent_mem  [TABLE_ENTRIES];
  bit [31:0] cost_mem    [TABLE_ENTRIES];
  bit        parent_known[TABLE_ENTRIES];
  bit [7:0]  cur_epoch;
  bit [15:0] mark_run_count;
  int        known_entries[$];
  int        episode_chain[$];

  rsp_t table_replies[$];

  int errors = 0;
  int items_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic int route_cap(logic [6:0] lim_raw);
    int lim;
    lim = lim_raw;
    if (lim < 1) lim = 1;
    if (lim > ROUTE_MAX) lim = ROUTE_MAX;
    return lim;
  endfunction

  // Work out the result beats of one accepted request and update the table.
  task automatic apply_table_op(req_t r);
    rsp_t o;
    logic ok;
    logic stop;
    logic [7:0] new_tag;
    logic [11:0] hop;
    int lim;
    int pos;
    ok = (r.index < TABLE_ENTRIES);
    o = '0;
    case (r.op)
      OP_NEW_SEARCH: begin
        if (cur_epoch == EPOCH_LAST) begin
          foreach (tag_mem[i]) tag_mem[i] = '0;
          cur_epoch = '0;
        end
        cur_epoch = cur_epoch + 8'd1;
      end
      OP_ADD: begin
        if (ok && r.parent_index < TABLE_ENTRIES) begin
          cost_mem[r.index] = r.move_cost;
          tag_mem[r.index] = cur_epoch;
          parent_mem[r.index] = r.parent_index[11:0];
          if (!parent_known[r.index]) begin
            parent_known[r.index] = 1'b1;
            known_entries.push_back(r.index);
          end
        end else begin
          o.bad_index = 1'b1;
        end
      end
      OP_MARK_GIVEN, OP_MARK_CUR: begin
        new_tag = (r.op == OP_MARK_GIVEN) ? r.tag_value : cur_epoch;
        if (ok) begin
          tag_mem[r.index] = new_tag;
          mark_run_count = mark_run_count + 16'd1;
        end
        cur_epoch = new_tag;
        o.bad_index = !ok;
        o.marked_count = mark_run_count;
        if (r.run_last) mark_run_count = '0;
      end
      OP_QUERY: begin
        if (ok) begin
          o.is_current = (tag_mem[r.index] == cur_epoch);
          o.parent_out = parent_mem[r.index];
          o.cost_out = cost_mem[r.index];
        end else begin
          o.bad_index = 1'b1;
        end
      end
      OP_TRACE: begin
        if (!ok) begin
          o.bad_index = 1'b1;
        end else begin
          lim = route_cap(r.route_limit);
          hop = r.index[11:0];
          pos = 0;
          stop = 1'b0;
          while (hop != r.end_index && !stop) begin
            o = '0;
            o.epoch_out = cur_epoch;
            o.route_point = hop;
            pos++;
            if (pos >= lim) begin
              o.overflow = 1'b1;
              stop = 1'b1;
            end else begin
              table_replies.push_back(o);
              hop = parent_mem[hop];
            end
          end
          if (!stop) begin
            o = '0;
            o.route_point = r.end_index;
            o.final_position = pos[5:0];
          end
        end
      end
      default: ;
    endcase
    o.epoch_out = cur_epoch;
    o.last = 1'b1;
    table_replies.push_back(o);
  endtask

  // Move the end of a trace so that the walk never reads a parent that was
  // never written: the walk then stops on the first such entry instead.
  function automatic logic [11:0] safe_end(logic [11:0] start, logic [11:0] stop_at,
                                           logic [6:0] lim_raw);
    int lim;
    int pos;
    logic [11:0] hop;
    lim = route_cap(lim_raw);
    hop = start;
    pos = 0;
    while (hop != stop_at) begin
      pos++;
      if (pos >= lim) return stop_at;
      if (!parent_known[hop]) return hop;
      hop = parent_mem[hop];
    end
    return stop_at;
  endfunction

  function automatic int pick_known_entry();
    if (known_entries.size() == 0) return TABLE_ENTRIES;
    return known_entries[$urandom_range(0, known_entries.size() - 1)];
  endfunction

  function automatic int pick_chain_node();
    if (episode_chain.size() == 0) return pick_known_entry();
    return episode_chain[$urandom_range(0, episode_chain.size() - 1)];
  endfunction

  function automatic int bad_entry();
    return $urandom_range(TABLE_ENTRIES, 65535);
  endfunction

  function automatic req_t make_req(logic [2:0] op, logic [15:0] idx, logic [15:0] parent,
                                    logic [31:0] cost, logic [7:0] tag, logic [11:0] stop_at,
                                    logic [6:0] lim, logic run_last);
    req_t r;
    r.op = op;
    r.index = idx;
    r.parent_index = parent;
    r.move_cost = cost;
    r.tag_value = tag;
    r.end_index = stop_at;
    r.route_limit = lim;
    r.run_last = run_last;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.op = $urandom_range(0, 7);
    r.index = $urandom;
    r.parent_index = $urandom;
    r.move_cost = $urandom;
    r.tag_value = $urandom;
    r.end_index = $urandom;
    r.route_limit = $urandom;
    r.run_last = $urandom;
    return r;
  endfunction

  // Offer one beat, with a random idle gap first, and predict it once taken.
  task automatic send_beat(req_t r);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    apply_table_op(r);
    items_sent++;
  endtask

  task automatic wait_for_replies();
    req_valid <= 1'b0;
    while (table_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_noise_beat();
    req_t r;
    r = random_request();
    if ($urandom_range(1) == 1) r.index = $urandom_range(0, TABLE_ENTRIES - 1);
    if (r.op == OP_QUERY && r.index < TABLE_ENTRIES && !parent_known[r.index])
      r.index = pick_known_entry();
    if (r.op == OP_TRACE && r.index < TABLE_ENTRIES)
      r.end_index = safe_end(r.index[11:0], r.end_index, r.route_limit);
    send_beat(r);
  endtask

  // One search: optional new search, a chain of adds, a mark run, queries,
  // traces back along the chain, and a little noise.
  task automatic run_search_episode();
    req_t r;
    int len;
    int n;
    episode_chain.delete();
    if ($urandom_range(99) < 70) begin
      r = random_request();
      r.op = OP_NEW_SEARCH;
      send_beat(r);
    end
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      r = random_request();
      r.op = OP_ADD;
      r.index = ($urandom_range(1) == 1) ? $urandom_range(0, 63)
                                         : $urandom_range(0, TABLE_ENTRIES - 1);
      r.parent_index = (episode_chain.size() == 0) ? pick_known_entry() : episode_chain[$];
      if ($urandom_range(99) < 6) r.index = bad_entry();
      else if ($urandom_range(99) < 6) r.parent_index = bad_entry();
      send_beat(r);
      if (r.index < TABLE_ENTRIES && r.parent_index < TABLE_ENTRIES)
        episode_chain.push_back(r.index);
    end
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      r = random_request();
      r.op = ($urandom_range(99) < 80) ? OP_MARK_CUR : OP_MARK_GIVEN;
      if ($urandom_range(99) < 60) r.tag_value = cur_epoch;
      r.index = ($urandom_range(99) < 10) ? bad_entry() : pick_chain_node();
      r.run_last = (i == n - 1);
      send_beat(r);
    end
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      r = random_request();
      r.op = OP_QUERY;
      r.index = ($urandom_range(99) < 10) ? bad_entry() : pick_chain_node();
      send_beat(r);
    end
    n = $urandom_range(1, 2);
    for (int i = 0; i < n; i++) begin
      r = random_request();
      r.op = OP_TRACE;
      if ($urandom_range(99) < 10) r.index = bad_entry();
      else if (episode_chain.size() != 0 && $urandom_range(99) < 70) r.index = episode_chain[$];
      else r.index = pick_known_entry();
      case ($urandom_range(0, 4))
        0, 1, 2: r.end_index = pick_chain_node();
        3:       r.end_index = $urandom_range(0, TABLE_ENTRIES - 1);
        default: r.end_index = r.index[11:0];
      endcase
      r.route_limit = ($urandom_range(99) < 70) ? $urandom_range(1, 16) : $urandom_range(0, 127);
      if (r.index < TABLE_ENTRIES)
        r.end_index = safe_end(r.index[11:0], r.end_index, r.route_limit);
      send_beat(r);
    end
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) send_noise_beat();
  endtask

  task automatic test_directed_ops();
    idle_pct = 0;
    stall_pct = 0;
    send_beat(make_req(OP_QUERY, 16'd4096, 0, 0, 0, 0, 0, 0));
    send_beat(make_req(OP_NEW_SEARCH, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_req(OP_ADD, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
    send_beat(make_req(OP_ADD, 16'd4095, 0, 32'h7fff_ffff, 0, 0, 0, 0));
    send_beat(make_req(OP_ADD, 1, 16'd4095, 32'hffff_ffff, 0, 0, 0, 0));
    send_beat(make_req(OP_ADD, 16'd4096, 0, 32'd5, 0, 0, 0, 0));
    send_beat(make_req(OP_ADD, 2, 16'hffff, 32'd6, 0, 0, 0, 0));
    send_beat(make_req(OP_ADD, 16'hffff, 16'd4096, 32'd7, 0, 0, 0, 0));
    send_beat(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_req(OP_QUERY, 16'd4095, 0, 0, 0, 0, 0, 0));
    send_beat(make_req(OP_QUERY, 1, 0, 0, 0, 0, 0, 0));
    // Route 1 -> 4095 -> 0, then the same walk cut short by its limit.
    send_beat(make_req(OP_TRACE, 1, 0, 0, 0, 12'd0, 7'd64, 0));
    send_beat(make_req(OP_TRACE, 1, 0, 0, 0, 12'd0, 7'd2, 0));
    // Start equal to end, a zero limit, an unreachable end and a bad start.
    send_beat(make_req(OP_TRACE, 0, 0, 0, 0, 12'd0, 7'd0, 0));
    send_beat(make_req(OP_TRACE, 0, 0, 0, 0, 12'd1, 7'd0, 0));
    send_beat(make_req(OP_TRACE, 0, 0, 0, 0, 12'd3, 7'd127, 0));
    send_beat(make_req(OP_TRACE, 16'hffff, 0, 0, 0, 12'd4095, 7'd8, 0));
    send_beat(make_req(OP_MARK_CUR, 16'd4095, 0, 0, 0, 0, 0, 0));
    send_beat(make_req(OP_MARK_GIVEN, 16'd5000, 0, 0, 8'd7, 0, 0, 0));
    send_beat(make_req(OP_MARK_GIVEN, 1, 0, 0, 8'd255, 0, 0, 1));
    send_beat(make_req(OP_QUERY, 1, 0, 0, 0, 0, 0, 0));
    send_beat(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
    // The epoch is at its last value here, so this search clears all tags.
    send_beat(make_req(OP_NEW_SEARCH, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_req(OP_QUERY, 1, 0, 0, 0, 0, 0, 0));
    send_beat(make_req(OP_SPARE_A, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_req(OP_SPARE_B, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_req(OP_MARK_CUR, 0, 0, 0, 0, 0, 0, 1));
    wait_for_replies();
  endtask

  task automatic test_random_searches(int count, int send_idle, int recv_stall);
    int stop_at;
    stop_at = items_sent + count;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    while (items_sent < stop_at) run_search_episode();
    wait_for_replies();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so the
  // block backs up and stalls its input.
  task automatic test_result_backpressure();
    int stop_at;
    idle_pct = 0;
    stall_pct = 0;
    stop_at = items_sent + 20;
    hold_requests++;
    while (items_sent < stop_at) run_search_episode();
    wait_for_replies();
  endtask

  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      rsp_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_beat
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (table_replies.size() == 0) begin
        $error("result beat with nothing outstanding: %p", rsp);
        errors++;
      end else begin
        want = table_replies.pop_front();
        check_field("route_point", want.route_point, rsp.route_point);
        check_field("last", want.last, rsp.last);
        check_field("overflow", want.overflow, rsp.overflow);
        check_field("bad_index", want.bad_index, rsp.bad_index);
        check_field("is_current", want.is_current, rsp.is_current);
        check_field("parent_out", want.parent_out, rsp.parent_out);
        check_field("cost_out", want.cost_out, rsp.cost_out);
        check_field("marked_count", want.marked_count, rsp.marked_count);
        check_field("epoch_out", want.epoch_out, rsp.epoch_out);
        check_field("final_position", want.final_position, rsp.final_position);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_random_searches(40, 0, 0);
    test_random_searches(30, 81, 0);
    test_random_searches(30, 0, 81);
    test_random_searches(30, 29, 29);
    test_result_backpressure();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/ettpt_pkg.sv
rtl/ettpt_ram.sv
rtl/epoch_tag_table_with_parent_trace.sv
dv/tb.sv
